### hw/rtl/psq_pkg.sv
// Shared constants, scale tables and helper functions for the pitch scale quantizer.
`timescale 1ns / 1ps

package psq_pkg;

  localparam int FIELD_W         = 21;
  localparam int MODE_W          = 3;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAX_DEGREES_DEF = 13;

  localparam int TABLE_BITS = 24;
  localparam int Q_W        = TABLE_BITS + 1;
  localparam int SLOTS      = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int TBL_W      = 2;

  localparam int OUT_MAX = (1 << (FIELD_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (FIELD_W - 1));

  // tenth of a semitone, Q0.24
  localparam logic [Q_W-1:0] TIE_Q24 = Q_W'(139810);

  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EVEN12 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EVEN8  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_JUST12 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_JUST8  = 3'd4;

  localparam logic [TBL_W-1:0] TBL_EVEN12 = 2'd0;
  localparam logic [TBL_W-1:0] TBL_EVEN8  = 2'd1;
  localparam logic [TBL_W-1:0] TBL_JUST12 = 2'd2;
  localparam logic [TBL_W-1:0] TBL_JUST8  = 2'd3;

  localparam int CNT12 = 13;
  localparam int CNT8  = 8;

  // Degree tables in Q0.24, padded with the octave.
  localparam logic [Q_W-1:0] EVEN12 [SLOTS] = '{
    25'd0, 25'd1398101, 25'd2796203, 25'd4194304, 25'd5592405, 25'd6990507,
    25'd8388608, 25'd9786709, 25'd11184811, 25'd12582912, 25'd13981013,
    25'd15379115, 25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216
  };
  localparam logic [Q_W-1:0] EVEN8 [SLOTS] = '{
    25'd0, 25'd2796203, 25'd5592405, 25'd6990507, 25'd9786709, 25'd12582912,
    25'd15379115, 25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216,
    25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216
  };
  localparam logic [Q_W-1:0] JUST12 [SLOTS] = '{
    25'd0, 25'd1562117, 25'd2850868, 25'd4412985, 25'd5401057, 25'd6963174,
    25'd8251926, 25'd9814042, 25'd11376159, 25'd12364231, 25'd14227027,
    25'd15215099, 25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216
  };
  localparam logic [Q_W-1:0] JUST8 [SLOTS] = '{
    25'd0, 25'd2850868, 25'd5401057, 25'd6963174, 25'd9814042, 25'd12364231,
    25'd15215099, 25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216,
    25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216
  };

  function automatic logic [Q_W-1:0] psq_deg_q24(input logic [TBL_W-1:0] tbl,
                                                 input logic [IDX_W-1:0] idx);
    logic [Q_W-1:0] d;
    case (tbl)
      TBL_EVEN12: d = EVEN12[idx];
      TBL_EVEN8:  d = EVEN8[idx];
      TBL_JUST12: d = JUST12[idx];
      TBL_JUST8:  d = JUST8[idx];
      default:    d = EVEN12[idx];
    endcase
    return d;
  endfunction

  // Q0.24 to frac_bits fraction bits, round half up.
  function automatic logic [Q_W-1:0] psq_to_frac(input logic [Q_W-1:0] q24,
                                                 input int frac_bits);
    int          sh;
    logic [Q_W:0] sum;
    sh  = TABLE_BITS - frac_bits;
    sum = {1'b0, q24} + (((Q_W + 1)'(1) << sh) >> 1);
    return Q_W'(sum >> sh);
  endfunction

endpackage

### hw/rtl/pitch_scale_quantizer.sv
// Throughput: one beat per cycle while out_stall is low; input register, single-pass snap logic, output register.
// Stalls propagate back through both registers; no bubbles while out_stall is low.
// Reset (rst, synchronous): clears both valid flags and sets scale_mode to off.
// Top level of the pitch scale quantizer.
`timescale 1ns / 1ps

module pitch_scale_quantizer #(
  parameter int FRAC_BITS   = psq_pkg::FRAC_BITS_DEF,
  parameter int MAX_DEGREES = psq_pkg::MAX_DEGREES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic        [psq_pkg::MODE_W-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [psq_pkg::FIELD_W-1:0] voltage_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [psq_pkg::FIELD_W-1:0] voltage_out
);
  import psq_pkg::*;

  logic [MODE_W-1:0]         scale_mode;
  logic                      held_valid;
  logic signed [FIELD_W-1:0] held_voltage;
  logic signed [FIELD_W-1:0] snap_result;
  logic                      s2_ready;

  assign s2_ready = !out_valid || !out_stall;
  assign in_stall = held_valid && !s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode <= MODE_OFF;
    end else if (cfg_we) begin
      scale_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_voltage <= voltage_in;
    end
  end

  psq_snap #(
    .FRAC_BITS   (FRAC_BITS),
    .MAX_DEGREES (MAX_DEGREES)
  ) u_snap (
    .mode    (scale_mode),
    .voltage (held_voltage),
    .result  (snap_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && held_valid) begin
      voltage_out <= snap_result;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !held_valid)
    else $error("valid flags not cleared by reset");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    held_valid && s2_ready |=> out_valid)
    else $error("held beat lost on advance");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !held_valid |=> !out_valid)
    else $error("output beat repeated");

  a_passthru: assert property (@(posedge clk) disable iff (rst)
    held_valid && s2_ready && scale_mode == MODE_OFF
      |=> voltage_out == $past(held_voltage))
    else $error("mode off does not pass the input through");

endmodule

### hw/rtl/psq_snap.sv
// Combinational snap of one pitch value to the nearest degree of the selected scale.
`timescale 1ns / 1ps

module psq_snap #(
  parameter int FRAC_BITS   = psq_pkg::FRAC_BITS_DEF,
  parameter int MAX_DEGREES = psq_pkg::MAX_DEGREES_DEF
) (
  input  logic        [psq_pkg::MODE_W-1:0]  mode,
  input  logic signed [psq_pkg::FIELD_W-1:0] voltage,
  output logic signed [psq_pkg::FIELD_W-1:0] result
);
  import psq_pkg::*;

  localparam int DW   = FRAC_BITS + 1;
  localparam int VW   = ((FIELD_W > FRAC_BITS) ? FIELD_W : FRAC_BITS) + 2;
  localparam int USE12 = (MAX_DEGREES < CNT12) ? MAX_DEGREES : CNT12;
  localparam int USE8  = (MAX_DEGREES < CNT8) ? MAX_DEGREES : CNT8;
  localparam logic [Q_W-1:0] TIE_FULL = psq_to_frac(TIE_Q24, FRAC_BITS);
  localparam logic signed [VW-1:0] SAT_HI = VW'(OUT_MAX);
  localparam logic signed [VW-1:0] SAT_LO = VW'(OUT_MIN);

  logic                 quant;
  logic [TBL_W-1:0]     tbl;
  logic [CNT_W-1:0]     cnt;
  logic [Q_W-1:0]       deg_full [SLOTS];
  logic [DW-1:0]        deg [SLOTS];

  logic signed [VW-1:0] v_ext;
  logic signed [VW-1:0] octave;
  logic signed [VW-1:0] r_sum;
  logic [FRAC_BITS-1:0] f;
  logic [DW-1:0]        f_ext;
  logic [DW-1:0]        lo;
  logic [DW-1:0]        hi;
  logic                 have_hi;
  logic [DW-1:0]        dlo;
  logic [DW-1:0]        dhi;
  logic signed [DW:0]   gap_s;
  logic [DW-1:0]        gap;
  logic [DW-1:0]        tie;
  logic [DW-1:0]        pick;

  always_comb begin
    case (mode)
      MODE_EVEN12: begin quant = 1'b1; tbl = TBL_EVEN12; cnt = CNT_W'(USE12); end
      MODE_EVEN8:  begin quant = 1'b1; tbl = TBL_EVEN8;  cnt = CNT_W'(USE8);  end
      MODE_JUST12: begin quant = 1'b1; tbl = TBL_JUST12; cnt = CNT_W'(USE12); end
      MODE_JUST8:  begin quant = 1'b1; tbl = TBL_JUST8;  cnt = CNT_W'(USE8);  end
      default:     begin quant = 1'b0; tbl = TBL_EVEN12; cnt = '0;            end
    endcase
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_deg
    assign deg_full[g] = psq_to_frac(psq_deg_q24(tbl, IDX_W'(g)), FRAC_BITS);
    assign deg[g]      = deg_full[g][DW-1:0];
  end

  always_comb begin
    v_ext  = VW'(voltage);
    f      = v_ext[FRAC_BITS-1:0];
    f_ext  = DW'(f);
    octave = v_ext - $signed({{(VW - FRAC_BITS){1'b0}}, f});

    // tables ascend: last degree at or below, first at or above
    lo      = '0;
    hi      = '0;
    have_hi = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (CNT_W'(i) < cnt) begin
        if (deg[i] <= f_ext) begin
          lo = deg[i];
        end
        if (deg[i] >= f_ext && !have_hi) begin
          hi      = deg[i];
          have_hi = 1'b1;
        end
      end
    end

    dlo   = f_ext - lo;
    dhi   = hi - f_ext;
    gap_s = $signed({1'b0, dhi}) - $signed({1'b0, dlo});
    gap   = gap_s[DW] ? DW'(-gap_s) : gap_s[DW-1:0];
    tie   = TIE_FULL[DW-1:0];

    if (!have_hi || hi == lo || gap < tie) begin
      pick = lo;
    end else begin
      pick = (dhi < dlo) ? hi : lo;
    end

    r_sum = octave + $signed({{(VW - DW){1'b0}}, pick});

    if (!quant) begin
      result = voltage;
    end else if (r_sum > SAT_HI) begin
      result = FIELD_W'(SAT_HI);
    end else if (r_sum < SAT_LO) begin
      result = FIELD_W'(SAT_LO);
    end else begin
      result = r_sum[FIELD_W-1:0];
    end
  end

endmodule
